// ===== hw/rtl/fpcvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcvt_pkg
// shared types and constants for the binary32 / binary16 / bfloat16 converter
// ----------------------------------------------------------------------------
package fpcvt_pkg;

	typedef enum logic [1:0] {
		MODE_FP32_TO_FP16 = 2'd0,
		MODE_FP16_TO_FP32 = 2'd1,
		MODE_FP32_TO_BF16 = 2'd2,
		MODE_BF16_TO_FP32 = 2'd3
	} mode_t;

	localparam int unsigned WordW = 32;

	localparam logic [15:0] HalfQnan = 16'h7FFF;
	localparam logic [14:0] HalfInf  = 15'h7C00;

	// binary32 bias 127 minus binary16 bias 15
	localparam logic [7:0] BiasDiff   = 8'd112;
	// binary32 exponent of a half denormal before the shift is removed
	localparam logic [7:0] DenormBase = 8'd113;
	localparam logic [7:0] Fp32ExpMax = 8'hFF;
	localparam logic [4:0] HalfExpMax = 5'h1F;

endpackage

// ===== hw/rtl/fpcvt_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcvt_core
// combinational conversion of one bit pattern selected by mode
// ----------------------------------------------------------------------------
module fpcvt_core import fpcvt_pkg::*; (
	input  mode_t             mode,
	input  logic [WordW-1:0]  in_bits,
	output logic [WordW-1:0]  out_bits
);

	// narrowing to binary16
	logic        n_sgn;
	logic [7:0]  n_exp;
	logic [22:0] n_man;
	logic [9:0]  n_ebias;
	logic [15:0] n_res;

	// widening from binary16
	logic        w_sgn;
	logic [4:0]  w_exp;
	logic [9:0]  w_man;
	logic [3:0]  w_shift;
	logic [10:0] w_norm;
	logic [31:0] w_res;

	assign n_sgn   = in_bits[31];
	assign n_exp   = in_bits[30:23];
	assign n_man   = in_bits[22:0];
	assign n_ebias = {2'b00, n_exp} - {2'b00, BiasDiff};

	always_comb begin
		if (n_exp == Fp32ExpMax) begin
			if (n_man != '0) begin
				n_res = HalfQnan;
			end else begin
				n_res = {n_sgn, HalfInf};
			end
		end else if (n_exp == '0 || n_ebias[9] || n_ebias == '0) begin
			n_res = {n_sgn, 15'd0};
		end else if (n_ebias >= {5'd0, HalfExpMax}) begin
			n_res = {n_sgn, HalfInf};
		end else begin
			n_res = {n_sgn, n_ebias[4:0], n_man[22:13]};
		end
	end

	assign w_sgn = in_bits[15];
	assign w_exp = in_bits[14:10];
	assign w_man = in_bits[9:0];

	// shift that brings the leading one to bit 10
	always_comb begin
		w_shift = 4'd11;
		for (int i = 0; i < 10; i++) begin
			if (w_man[i]) begin
				w_shift = 4'(10 - i);
			end
		end
	end

	assign w_norm = {1'b0, w_man} << w_shift;

	always_comb begin
		if (w_exp == '0) begin
			if (w_man == '0) begin
				w_res = {w_sgn, 31'd0};
			end else begin
				w_res = {w_sgn, DenormBase - {4'd0, w_shift}, w_norm[9:0], 13'd0};
			end
		end else if (w_exp == HalfExpMax) begin
			w_res = {w_sgn, Fp32ExpMax, w_man, 13'd0};
		end else begin
			w_res = {w_sgn, {3'd0, w_exp} + BiasDiff, w_man, 13'd0};
		end
	end

	always_comb begin
		unique case (mode)
			MODE_FP32_TO_FP16: out_bits = {16'd0, n_res};
			MODE_FP16_TO_FP32: out_bits = w_res;
			MODE_FP32_TO_BF16: out_bits = {16'd0, in_bits[31:16]};
			MODE_BF16_TO_FP32: out_bits = {in_bits[15:0], 16'd0};
			default:           out_bits = '0;
		endcase
	end

endmodule

// ===== hw/rtl/fp32_fp16_bf16_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fp32_fp16_bf16_converter
// streaming converter between binary32 and binary16 or bfloat16
// ----------------------------------------------------------------------------
//  channel | signals                        | beat
//  in      | in_valid, in_ready, mode, in_bits | one source word
//  out     | out_valid, out_ready, out_bits   | one converted word
//
//  one beat per cycle sustained while out_ready stays high; input register,
//  then conversion logic into the result register
//  stalls on out_ready hold the result register; the input register still
//  takes one more beat while the result waits
//  reset clears both valid flags only
// ----------------------------------------------------------------------------
module fp32_fp16_bf16_converter import fpcvt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [WordW-1:0] in_bits,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WordW-1:0] out_bits
);

	logic             valid_s1;
	mode_t            mode_s1;
	logic [WordW-1:0] bits_s1;
	logic             valid_s2;
	logic [WordW-1:0] res_s2;
	logic [WordW-1:0] conv;
	logic             s2_free;
	logic             adv_s1;

	assign s2_free  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_s1 <= mode_t'(mode);
			bits_s1 <= in_bits;
		end
	end

	fpcvt_core u_core (
		.mode     (mode_s1),
		.in_bits  (bits_s1),
		.out_bits (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= conv;
		end
	end

	assign out_valid = valid_s2;
	assign out_bits  = res_s2;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused with empty input register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(bits_s1) && $stable(mode_s1)))
		else $error("held beat lost from input register");

	a_narrow_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (mode_s1 == MODE_FP32_TO_FP16 || mode_s1 == MODE_FP32_TO_BF16))
		|=> (out_bits[31:16] == '0))
		else $error("narrowed result has nonzero upper half");

	a_bf16_widen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && mode_s1 == MODE_BF16_TO_FP32)
		|=> (out_bits[15:0] == '0 && out_bits[31:16] == $past(bits_s1[15:0])))
		else $error("bfloat16 widening wrong");

endmodule

// ===== test/fpcvt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpcvt_checker
// watches both channels of the converter, works out the converted word for
// every accepted input beat and compares each output beat, in order, with the
// oldest word still owed; counts failures, pending words and checked beats
// ----------------------------------------------------------------------------
module fpcvt_checker import fpcvt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [1:0]       mode,
	input  logic [WordW-1:0] in_bits,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [WordW-1:0] out_bits,
	output int               failures,
	output int               pending,
	output int               checked
);

	logic [WordW-1:0] owed_words[$];

	function automatic logic [15:0] narrow_to_half(logic [31:0] w);
		logic [15:0] sgn;
		logic [7:0]  ex;
		logic [22:0] man;
		int          e;
		sgn = {w[31], 15'd0};
		ex  = w[30:23];
		man = w[22:0];
		if (ex == Fp32ExpMax) begin
			if (man != '0)
				return HalfQnan;
			return sgn | {1'b0, HalfInf};
		end
		if (ex == '0)
			return sgn;
		e = int'(ex) - int'(BiasDiff);
		// signed test, so tiny values go to zero rather than wrapping
		if (e <= 0)
			return sgn;
		if (e >= 31)
			return sgn | {1'b0, HalfInf};
		return sgn | {1'b0, 5'(e), man[22:13]};
	endfunction

	function automatic logic [31:0] widen_half(logic [15:0] h);
		logic [4:0]  ex;
		logic [10:0] man;
		int          shift;
		ex  = h[14:10];
		man = {1'b0, h[9:0]};
		if (ex == '0) begin
			if (man == '0)
				return {h[15], 31'd0};
			shift = 0;
			// normalise the denormal until the hidden bit appears
			while (!man[10]) begin
				man = man << 1;
				shift++;
			end
			return {h[15], 8'(int'(DenormBase) - shift), man[9:0], 13'd0};
		end
		if (ex == HalfExpMax)
			return {h[15], Fp32ExpMax, h[9:0], 13'd0};
		return {h[15], 8'({3'd0, ex} + BiasDiff), h[9:0], 13'd0};
	endfunction

	function automatic logic [31:0] convert_word(mode_t m, logic [31:0] w);
		case (m)
			MODE_FP32_TO_FP16: return {16'd0, narrow_to_half(w)};
			MODE_FP16_TO_FP32: return widen_half(w[15:0]);
			MODE_FP32_TO_BF16: return {16'd0, w[31:16]};
			default:           return {w[15:0], 16'd0};
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			owed_words.delete();
			failures = 0;
			pending  = 0;
			checked  = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (owed_words.size() == 0) begin
					$error("out_bits beat with nothing owed: actual %08h", out_bits);
					failures++;
				end else begin
					want = owed_words.pop_front();
					checked++;
					if (out_bits !== want) begin
						$error("out_bits mismatch: expected %08h, actual %08h", want, out_bits);
						failures++;
					end
				end
			end
			if (in_valid && in_ready)
				owed_words.push_back(convert_word(mode_t'(mode), in_bits));
			pending = owed_words.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives the fp32 / fp16 / bf16 converter with edge-case words for every mode
// and then with random words biased towards special exponents, under three
// idling mixes and one long output stall; the checker gives the verdict data
// ----------------------------------------------------------------------------
module testbench import fpcvt_pkg::*;;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic [1:0]       mode      = '0;
	logic [WordW-1:0] in_bits   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [WordW-1:0] out_bits;

	int failures;
	int pending;
	int checked;

	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	bit hold_off_req = 1'b0;
	int mode_count[4] = '{0, 0, 0, 0};

	always #6 clk = ~clk;

	fp32_fp16_bf16_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.in_bits   (in_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_bits  (out_bits)
	);

	fpcvt_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.in_bits   (in_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_bits  (out_bits),
		.failures  (failures),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 48;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_word(input mode_t m, input logic [31:0] w);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		in_bits  <= w;
		do
			@(posedge clk);
		while (!in_ready);
		mode_count[m]++;
	endtask

	function automatic logic [31:0] random_source(mode_t m);
		logic [31:0] w;
		int          pick;
		w    = $urandom;
		pick = $urandom_range(0, 9);
		if (m == MODE_FP32_TO_FP16) begin
			case (pick)
				0: w[30:23] = 8'h00;
				1: w[30:23] = 8'hFF;
				2: begin
					w[30:23] = 8'hFF;
					w[22:0]  = '0;
				end
				3, 4, 5, 6: w[30:23] = 8'($urandom_range(108, 147));
				default: ;
			endcase
		end else if (m == MODE_FP16_TO_FP32) begin
			case (pick)
				0: w[14:10] = 5'h00;
				1: w[14:10] = 5'h1F;
				2: begin
					w[14:10] = 5'h00;
					w[9:0]   = 10'(1 << $urandom_range(0, 9));
				end
				3: begin
					w[14:10] = 5'h1F;
					w[9:0]   = '0;
				end
				default: ;
			endcase
		end
		return w;
	endfunction

	initial begin
		mode_t m;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 18;
		rx_idle_pct = 69;

		// edge cases, fp32 to fp16
		send_word(MODE_FP32_TO_FP16, 32'h0000_0000);
		send_word(MODE_FP32_TO_FP16, 32'h8000_0000);
		send_word(MODE_FP32_TO_FP16, 32'h0000_0001);
		send_word(MODE_FP32_TO_FP16, 32'h807F_FFFF);
		send_word(MODE_FP32_TO_FP16, 32'h7FC0_0000);
		send_word(MODE_FP32_TO_FP16, 32'hFFFF_FFFF);
		send_word(MODE_FP32_TO_FP16, 32'h7F80_0000);
		send_word(MODE_FP32_TO_FP16, 32'hFF80_0000);
		send_word(MODE_FP32_TO_FP16, 32'hB800_0000);
		send_word(MODE_FP32_TO_FP16, 32'h3880_0000);
		send_word(MODE_FP32_TO_FP16, 32'h477F_FFFF);
		send_word(MODE_FP32_TO_FP16, 32'hC780_0000);
		// fp16 to fp32, upper half ignored
		send_word(MODE_FP16_TO_FP32, 32'h0000_0000);
		send_word(MODE_FP16_TO_FP32, 32'hFFFF_8000);
		send_word(MODE_FP16_TO_FP32, 32'h0000_0001);
		send_word(MODE_FP16_TO_FP32, 32'h0000_83FF);
		send_word(MODE_FP16_TO_FP32, 32'hA5A5_0200);
		send_word(MODE_FP16_TO_FP32, 32'h0000_7C00);
		send_word(MODE_FP16_TO_FP32, 32'h0000_FC00);
		send_word(MODE_FP16_TO_FP32, 32'h0000_7E01);
		send_word(MODE_FP16_TO_FP32, 32'hFFFF_3C00);
		// bfloat16 both ways
		send_word(MODE_FP32_TO_BF16, 32'hFFFF_FFFF);
		send_word(MODE_FP32_TO_BF16, 32'h1234_5678);
		send_word(MODE_BF16_TO_FP32, 32'hFFFF_8001);
		send_word(MODE_BF16_TO_FP32, 32'h0000_FFFF);

		for (int i = 0; i < 1200; i++) begin
			if (i == 400) begin
				tx_idle_pct = 69;
				rx_idle_pct = 18;
			end else if (i == 800) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
				hold_off_req = 1'b1;
			end
			m = mode_t'($urandom_range(0, 3));
			send_word(m, random_source(m));
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("summary: %0d words sent (fp32>fp16 %0d, fp16>fp32 %0d, %s %0d, %s %0d)",
			mode_count[0] + mode_count[1] + mode_count[2] + mode_count[3],
			mode_count[0], mode_count[1], "fp32>bf16", mode_count[2],
			"bf16>fp32", mode_count[3]);
		$display("summary: %0d results checked under %s",
			checked, "two idling mixes, a long output hold-off and back-to-back traffic");
		if (failures == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
